@@ rtl/core/fsmf_pkg.sv @@
// Shared types and constants for the first substring match finder.
package fsmf_pkg;

    // Pattern bytes kept at most; later bytes of a long pattern are dropped.
    localparam int unsigned PAT_CAP = 51;
    localparam int unsigned LEN_W   = 6;
    localparam int unsigned POS_W   = 12;
    localparam int unsigned BYTE_W  = 8;

    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [BYTE_W-1:0] t_byte;

    // Kind of an input beat, carried on tuser.
    typedef enum logic {
        ACT_PATTERN = 1'b0,
        ACT_TEXT    = 1'b1
    } t_action;

    // Shift enables broadcast to every cell of the chain.
    typedef struct packed {
        logic pat_shift;
        logic txt_shift;
    } t_shift_ctl;

endpackage

@@ rtl/core/first_substring_match_finder_core.sv @@
// Top level of the first substring match finder: cell chain and its control.
//
//  Channel  | Direction | Beat contents
//  ---------+-----------+------------------------------------------------------
//  i_s_*    | in        | tdata: data_byte[7:0]; tuser: action; tlast: last
//  o_m_*    | out       | tdata: position[11:0], zero filled to 16 bits;
//           |           | tuser: found
//
// Cycles: a pattern or text beat is taken in every cycle while no closed text
// waits. A text beat marked last closes the text; the input is then held off
// until its result is loaded into the output register, which waits for the
// compare of that final byte, if one is due, and for that register to be free.
// Reset: i_rst_n is synchronous and active low; it empties the pattern, the
// text count, the match record and the output register.
// Stalls: the input stays ready while an earlier result waits on the output;
// only the closing of a text waits for the output register to drain.
module first_substring_match_finder_core #(
    parameter int PATTERN_DEPTH = 64,
    parameter int TEXT_MAX      = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] action
    input  logic        i_s_tlast,   // last byte of the pattern or of the text
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [11:0] position, [15:12] zero
    output logic        o_m_tuser    // [0] found
);
    import fsmf_pkg::*;

    localparam int CNT_W = $clog2(TEXT_MAX);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(TEXT_MAX - 1);

    // Pattern side: length of the held pattern and whether a load is open.
    t_len             r_len,   n_len;
    logic             r_open,  n_open;
    // Text side: bytes taken, first match record.
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_seen,  n_seen;
    logic [CNT_W-1:0] r_start, n_start;
    // A compare of the window is due in this cycle.
    logic             r_chk,   n_chk;
    // A text has closed and its result has not yet been loaded.
    logic             r_res_pend, n_res_pend;
    // Output register.
    logic             r_out_valid, n_out_valid;
    logic             r_out_found, n_out_found;
    logic [POS_W-1:0] r_out_pos,   n_out_pos;

    t_shift_ctl       w_ctl;
    logic             w_accept;
    logic             w_is_pat;
    logic             w_is_text;
    logic             w_hit_all;
    logic             w_load;
    t_len             w_base;

    // Cell chain wiring: index k holds the k-th newest text byte and, for a
    // pattern of length L, the pattern byte L-1-k, so that a whole-pattern
    // match is simply every active cell reporting equality.
    t_byte            w_pat [PATTERN_DEPTH+1];
    t_byte            w_txt [PATTERN_DEPTH+1];
    logic [PATTERN_DEPTH-1:0] w_hits;

    assign w_pat[0] = i_s_tdata;
    assign w_txt[0] = i_s_tdata;

    for (genvar g = 0; g < PATTERN_DEPTH; g++) begin : g_cell
        fsmf_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk (i_clk),
            .i_ctl (w_ctl),
            .i_len (r_len),
            .i_pat (w_pat[g]),
            .i_txt (w_txt[g]),
            .o_pat (w_pat[g+1]),
            .o_txt (w_txt[g+1]),
            .o_hit (w_hits[g])
        );
    end

    assign w_hit_all = &w_hits;

    assign o_s_tready = !r_res_pend;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_is_pat   = w_accept && (t_action'(i_s_tuser) == ACT_PATTERN);
    assign w_is_text  = w_accept && (t_action'(i_s_tuser) == ACT_TEXT);

    // A pattern beat that arrives with no load open starts a fresh pattern.
    assign w_base          = r_open ? r_len : '0;
    assign w_ctl.pat_shift = w_is_pat && (int'(w_base) < PAT_CAP);
    // Once the count has saturated, further text bytes are not examined.
    assign w_ctl.txt_shift = w_is_text && (r_count != CNT_SAT);

    // The closed text's result may be loaded once its last compare is done
    // and the output register is free or draining.
    assign w_load = r_res_pend && !r_chk && (!r_out_valid || i_m_tready);

    always_comb begin
        n_len       = r_len;
        n_open      = r_open;
        n_count     = r_count;
        n_seen      = r_seen;
        n_start     = r_start;
        n_chk       = 1'b0;
        n_res_pend  = r_res_pend;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_pos   = r_out_pos;

        if (w_is_pat) begin
            n_open = !i_s_tlast;
            n_len  = w_ctl.pat_shift ? t_len'(w_base + 1'b1) : w_base;
        end

        if (w_is_text) begin
            n_open = 1'b0;
            if (i_s_tlast) begin
                n_res_pend = 1'b1;
            end
        end

        if (w_ctl.txt_shift) begin
            n_count = r_count + 1'b1;
            n_chk   = (r_len != '0) && ((r_count + 1'b1) >= CNT_W'(r_len));
        end

        // The window compare runs in the cycle after the byte went in; the
        // earliest match wins, as compares complete in text order.
        if (r_chk && w_hit_all && !r_seen) begin
            n_seen  = 1'b1;
            n_start = r_count - CNT_W'(r_len);
        end

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        if (w_load) begin
            n_out_valid = 1'b1;
            n_out_found = r_seen;
            n_out_pos   = r_seen ? POS_W'(r_start) : '0;
            n_res_pend  = 1'b0;
            n_count     = '0;
            n_seen      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_open      <= 1'b0;
            r_count     <= '0;
            r_seen      <= 1'b0;
            r_chk       <= 1'b0;
            r_res_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_open      <= n_open;
            r_count     <= n_count;
            r_seen      <= n_seen;
            r_chk       <= n_chk;
            r_res_pend  <= n_res_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start     <= n_start;
        r_out_found <= n_out_found;
        r_out_pos   <= n_out_pos;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_found;
    assign o_m_tdata  = {{(16 - POS_W){1'b0}}, r_out_pos};

endmodule

@@ rtl/core/fsmf_cell.sv @@
// One compare cell: holds a pattern byte and a text byte and reports a hit.
module fsmf_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic               i_clk,
    input  fsmf_pkg::t_shift_ctl i_ctl,
    input  fsmf_pkg::t_len     i_len,
    input  fsmf_pkg::t_byte    i_pat,
    input  fsmf_pkg::t_byte    i_txt,
    output fsmf_pkg::t_byte    o_pat,
    output fsmf_pkg::t_byte    o_txt,
    output logic               o_hit
);
    import fsmf_pkg::*;

    t_byte r_pat;
    t_byte r_txt;
    logic  w_active;

    always_ff @(posedge i_clk) begin
        if (i_ctl.pat_shift) begin
            r_pat <= i_pat;
        end
        if (i_ctl.txt_shift) begin
            r_txt <= i_txt;
        end
    end

    // A cell takes part in the compare only while it lies inside the pattern.
    assign w_active = (int'(i_len) > CELL_IDX);
    assign o_hit    = !w_active || (r_pat == r_txt);
    assign o_pat    = r_pat;
    assign o_txt    = r_txt;

endmodule
